// File: hdl/midi_nmq_pkg.sv
// package for the midi note message queue
// holds operation codes, message constants, result kinds and the controller state type
// no dependencies
package midi_nmq_pkg;

    // request operation codes
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_FLUSH    = 2'd2;

    // midi status bytes, channel goes in the low nibble
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

    // bytes in one note message
    localparam int unsigned MSG_LEN = 3;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_NOTE,
        ST_WR_VEL,
        ST_STATUS,
        ST_FL_READ,
        ST_FL_SEND
    } nmq_state_t;

endpackage

// File: hdl/midi_note_message_queue_core.sv
// top level of the midi note message queue
// depends on midi_nmq_pkg and midi_nmq_ram

// A byte ring buffer of DEPTH entries for three-byte midi note messages. A
// note-on or note-off request stores the status byte (0x90 or 0x80 with the
// channel in the low nibble), the note and the velocity, but only when all
// three fit with one slot kept free (fill + 3 <= DEPTH - 1); one status result
// reports whether the message was stored. A flush request sends every queued
// byte in order as byte results, marks the last one, and leaves the buffer
// empty; flushing an empty buffer and the unused operation code give no result.
// A queue request writes the status byte as it is taken, then the note and the
// velocity through the single ram write port, then loads the result; a rejected
// one goes straight to the result load. A flush reads and then sends each byte,
// as the ram read data is registered, and waits while the result side stalls.
// Requests are taken one at a time; a finished result waits in the output
// register while the next request is accepted.
// The buffer storage is not cleared at reset and needs no clearing pass.
module midi_note_message_queue_core #(
    parameter int DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [3:0] s_channel,
    input  logic [6:0] s_note,
    input  logic [6:0] s_velocity,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic       m_accepted,
    output logic [7:0] m_tx_byte,
    output logic       m_last
);

    import midi_nmq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    // largest fill that still leaves room for a message plus the spare slot
    localparam logic [CNT_W-1:0] MAX_FILL = CNT_W'(DEPTH - 1 - MSG_LEN);

    // ring pointer step with wrap at DEPTH
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    nmq_state_t state_reg, state_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;

    // captured message bytes and the fit decision
    logic [6:0] note_reg;
    logic [6:0] vel_reg;
    logic       ok_reg;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic       m_kind_reg;
    logic       m_accepted_reg;
    logic [7:0] m_tx_byte_reg;
    logic       m_last_reg;

    // ram ports
    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    logic             s_accept;
    logic             out_free;
    logic [CNT_W-1:0] fill;
    logic             fits;
    logic [7:0]       status_byte;
    logic             is_queue_op;
    logic             load_status;
    logic             load_byte;
    logic [PTR_W-1:0] rp_adv;

    assign s_accept = s_valid && s_ready;
    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // fill level from the two pointers
    always_comb begin
        if (wp_reg >= rp_reg) begin
            fill = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            fill = {1'b0, wp_reg} + CNT_W'(DEPTH) - {1'b0, rp_reg};
        end
    end

    assign fits        = (fill <= MAX_FILL);
    assign is_queue_op = (s_operation == OP_NOTE_ON) || (s_operation == OP_NOTE_OFF);
    assign status_byte = ((s_operation == OP_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                         | {4'b0000, s_channel};
    assign rp_adv      = advance(rp_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (is_queue_op) begin
                        state_next = fits ? ST_WR_NOTE : ST_STATUS;
                    end else if (s_operation == OP_FLUSH && rp_reg != wp_reg) begin
                        state_next = ST_FL_READ;
                    end
                end
            end
            ST_WR_NOTE: state_next = ST_WR_VEL;
            ST_WR_VEL:  state_next = ST_STATUS;
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FL_READ: state_next = ST_FL_SEND;
            ST_FL_SEND: begin
                if (out_free) begin
                    state_next = (rp_adv == wp_reg) ? ST_IDLE : ST_FL_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = status_byte;
        load_status = 1'b0;
        load_byte   = 1'b0;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_ready = aresetn;
                // status byte goes in the same cycle the request is taken
                if (s_accept && is_queue_op && fits) begin
                    ram_we  = 1'b1;
                    wp_next = advance(wp_reg);
                end
            end
            ST_WR_NOTE: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, note_reg};
                wp_next   = advance(wp_reg);
            end
            ST_WR_VEL: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, vel_reg};
                wp_next   = advance(wp_reg);
            end
            ST_STATUS: begin
                load_status = out_free;
            end
            ST_FL_READ: begin
                // read address is rp_reg, data shows up next cycle
            end
            ST_FL_SEND: begin
                if (out_free) begin
                    load_byte = 1'b1;
                    rp_next   = rp_adv;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_status || load_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    midi_nmq_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(ram_wdata),
        .raddr(rp_reg),
        .rdata(ram_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            note_reg <= s_note;
            vel_reg  <= s_velocity;
            ok_reg   <= fits;
        end
        if (load_status) begin
            m_kind_reg     <= KIND_STATUS;
            m_accepted_reg <= ok_reg;
            m_tx_byte_reg  <= 8'h00;
            m_last_reg     <= 1'b1;
        end else if (load_byte) begin
            m_kind_reg     <= KIND_BYTE;
            m_accepted_reg <= 1'b0;
            m_tx_byte_reg  <= ram_rdata;
            // last byte once the read pointer catches the write pointer
            m_last_reg     <= (rp_adv == wp_reg);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_accepted = m_accepted_reg;
    assign m_tx_byte  = m_tx_byte_reg;
    assign m_last     = m_last_reg;

endmodule

// File: hdl/midi_nmq_ram.sv
// generic simple dual port ram, one write port and one read port
// read data is registered; no dependencies
module midi_nmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: verif/midi_note_message_queue_core_tb.sv
// testbench for midi_note_message_queue_core: queue and flush requests checked against
// a cycle-free model of the byte ring buffer, with random gaps and stalls on both channels
// depends on midi_nmq_pkg and the midi note message queue rtl
`timescale 1ns / 1ps

module midi_note_message_queue_core_tb;

    import midi_nmq_pkg::*;

    localparam int DEPTH = 32;
    // no code for the fourth operation in the package, the block ignores it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles with no request or result moving before the run is called hung
    localparam int unsigned HANG_LIMIT = 4000;
    // settle time after the last result, well beyond one flush step
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic [7:0] tx_byte;
        logic       last;
    } nmq_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_NOTE_ON;
    logic [3:0] s_channel = 4'd0;
    logic [6:0] s_note = 7'd0;
    logic [6:0] s_velocity = 7'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic       m_accepted;
    logic [7:0] m_tx_byte;
    logic       m_last;

    // shadow of the ring buffer
    logic [7:0]  queued_bytes [DEPTH];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;

    // results still owed by the block, oldest first
    nmq_result_t pending_results [$];

    int unsigned error_count = 0;
    int unsigned hang_cycles = 0;
    // set to run both channels at full rate
    bit          full_rate = 1'b0;
    int unsigned stall_left = 0;

    midi_note_message_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_channel  (s_channel),
        .s_note     (s_note),
        .s_velocity (s_velocity),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_accepted (m_accepted),
        .m_tx_byte  (m_tx_byte),
        .m_last     (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // work out the results of one accepted request and update the shadow buffer
    task automatic predict_request(input logic [1:0] op, input logic [3:0] ch,
                                   input logic [6:0] nt, input logic [6:0] vel);
        int unsigned fill;
        logic [7:0]  msg [3];
        nmq_result_t res;
        case (op)
            OP_NOTE_ON, OP_NOTE_OFF: begin
                fill = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
                res = '0;
                res.kind = KIND_STATUS;
                res.last = 1'b1;
                // one slot always stays free
                if (fill + MSG_LEN <= DEPTH - 1) begin
                    msg[0] = ((op == OP_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                             | {4'h0, ch};
                    msg[1] = {1'b0, nt};
                    msg[2] = {1'b0, vel};
                    for (int i = 0; i < 3; i++) begin
                        queued_bytes[wr_ptr] = msg[i];
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                    end
                    res.accepted = 1'b1;
                end
                pending_results.push_back(res);
            end
            OP_FLUSH: begin
                // empty buffer gives nothing at all
                while (rd_ptr != wr_ptr) begin
                    res = '0;
                    res.kind = KIND_BYTE;
                    res.tx_byte = queued_bytes[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    res.last = (rd_ptr == wr_ptr);
                    pending_results.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (full_rate) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one request, hold it until taken, then maybe back off
    task automatic send_request(input logic [1:0] op, input logic [3:0] ch,
                                input logic [6:0] nt, input logic [6:0] vel);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_channel   <= ch;
        s_note      <= nt;
        s_velocity  <= vel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(op, ch, nt, vel);
        gap = pick_gap();
        // with no gap valid simply stays high for the next request
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result side back pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (full_rate) begin
            m_ready <= 1'b1;
        end else begin
            int unsigned roll;
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                m_ready <= 1'b1;
            end else if (roll < 95) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    // compare every taken result with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d byte 0x%02h",
                       m_kind, m_tx_byte);
                error_count++;
            end else begin
                nmq_result_t want;
                want = pending_results.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    error_count++;
                end
                if (m_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, m_accepted);
                    error_count++;
                end
                if (m_tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, m_tx_byte);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // hang detection: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            hang_cycles = 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("[midi_note_message_queue_core] ERROR");
            $finish;
        end else begin
            hang_cycles++;
        end
    end

    // field extremes for both message types, then send them out
    task automatic test_field_extremes();
        send_request(OP_NOTE_ON,  4'd0,  7'd0,   7'd0);
        send_request(OP_NOTE_ON,  4'd15, 7'd127, 7'd127);
        send_request(OP_NOTE_OFF, 4'd0,  7'd127, 7'd0);
        send_request(OP_NOTE_OFF, 4'd15, 7'd0,   7'd127);
        // payload fields of a flush carry nothing
        send_request(OP_FLUSH,    4'd15, 7'd127, 7'd127);
    endtask

    // unused code leaves the buffer alone, flush of an empty buffer is silent
    task automatic test_ignored_requests();
        send_request(OP_NOTE_OFF, 4'd9,  7'd60,  7'd64);
        send_request(OP_UNUSED,   4'd15, 7'd127, 7'd127);
        send_request(OP_UNUSED,   4'd0,  7'd0,   7'd0);
        send_request(OP_FLUSH,    4'd0,  7'd0,   7'd0);
        send_request(OP_FLUSH,    4'd0,  7'd0,   7'd0);
        send_request(OP_NOTE_ON,  4'd3,  7'd33,  7'd99);
    endtask

    // with the message left queued, nine more fill 30 of 32 slots, the next ones bounce, then drain all
    task automatic test_queue_full();
        for (int i = 0; i < 11; i++)
            send_request(OP_NOTE_ON, 4'($urandom), 7'($urandom), 7'($urandom));
        send_request(OP_NOTE_OFF, 4'($urandom), 7'($urandom), 7'($urandom));
        send_request(OP_FLUSH, 4'd0, 7'd0, 7'd0);
    endtask

    // mostly queue requests so the buffer often runs full, flushes now and then
    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned roll;
        logic [1:0]  op;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      op = OP_NOTE_ON;
            else if (roll < 85) op = OP_NOTE_OFF;
            else if (roll < 96) op = OP_FLUSH;
            else                op = OP_UNUSED;
            send_request(op, 4'($urandom), 7'($urandom), 7'($urandom));
            if (op != OP_UNUSED) sent++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_ignored_requests();
        test_queue_full();
        test_random_traffic(105);
        // no idling on either side for a stretch
        full_rate = 1'b1;
        test_random_traffic(60);
        full_rate = 1'b0;
        test_random_traffic(70);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("[midi_note_message_queue_core] OK");
        end else begin
            $display("[midi_note_message_queue_core] ERROR");
        end
        $finish;
    end

endmodule

// File: midi_note_message_queue_core.f
hdl/midi_nmq_pkg.sv
hdl/midi_nmq_ram.sv
hdl/midi_note_message_queue_core.sv
verif/midi_note_message_queue_core_tb.sv
